>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL core.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/tsst_pkg.sv
`timescale 1ns / 1ps
package tsst_pkg;

   // Default number of sensors held in the average memory.
   localparam int SENSOR_COUNT_DEFAULT = 30;

   // Field widths.
   localparam int INDEX_W  = 5;
   localparam int SAMPLE_W = 12;
   localparam int LEVEL_W  = 16;
   localparam int ALPHA_W  = 17;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING_FACTOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_THRESHOLD  = 1'd1;
   localparam int CSR_DATA_W = ALPHA_W;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE           = 17'd65536;
   localparam logic [ALPHA_W-1:0] SMOOTHING_RESET     = 17'd65536;
   localparam logic [LEVEL_W-1:0] THRESHOLD_RESET     = 16'd32768;

   // Level = floor(128*(LEVEL_SLOPE*d + LEVEL_OFFSET) / (DEN_SCALE*(4096+d)))
   // which is the sensor divider curve in Q3.13 with common factors removed.
   localparam logic [23:0] LEVEL_SLOPE  = 24'd13037994;
   localparam logic [31:0] LEVEL_OFFSET = 32'd3599949824;
   localparam logic [13:0] DEN_SCALE    = 14'd15625;

   localparam int PROD_W = 36;   // slope * sample, plus offset
   localparam int DEN_W  = 27;   // DEN_SCALE * (4096 + d)
   localparam int LOW_W  = 16;   // numerator bits shifted into the divider
   localparam int CNT_W  = 4;    // counts the 16 quotient bits

   typedef struct packed {
      logic [INDEX_W-1:0]  sensor_index;
      logic [SAMPLE_W-1:0] sample;
      logic                frame_end;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_W-1:0] sensor_id;
      logic [LEVEL_W-1:0] smoothed_level;
      logic               touched;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_EMA,
      ST_FIN
   } state_type;

endpackage

>>> hw/rtl/touch_sensor_smoothing_threshold_core.sv
`timescale 1ns / 1ps
// Touch sensor smoothing and threshold core.
// Input channel req_*: one item is a sensor index, a 12-bit ADC sample and a
// frame_end mark; it is taken on a clock edge with req_valid high and
// req_stall low. Result channel rsp_*: one item per input item, carrying the
// sensor id, the smoothed Q3.13 level and the touched flag (level strictly
// above the threshold register). Configuration goes through csr_we,
// csr_index and csr_wdata, one register per write, and the user must write
// only while the core is idle; the core leaves this to the user. On its way
// to the result register each item passes these steps: the acceptance
// edge registers the level products and the memory read, then a load step
// seeds the divider, the restoring divider produces the level one quotient
// bit per cycle, a smoothing step does the multiply and a final step writes
// back and presents the result. A new item is taken the cycle after the
// previous result is loaded, so the core never works on two items at once.
// The output register frees the core: the next item is accepted while the
// last result still waits. If the receiver stalls past the next item's
// finish, that item holds in its final step and req_stall stays high.
// Reset (synchronous) sets the first-frame flag, the register defaults and
// empties the result register; the average memory is not cleared.
`include "assert_macros.svh"

module touch_sensor_smoothing_threshold_core #(
   parameter int SENSOR_COUNT = tsst_pkg::SENSOR_COUNT_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tsst_pkg::req_payload_type             req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output tsst_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_we,
   input  logic [tsst_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tsst_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tsst_pkg::*;

   localparam int ADDR_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   // Configuration registers.
   logic [ALPHA_W-1:0] smoothing_ff;
   logic [LEVEL_W-1:0] threshold_ff;

   // Control.
   state_type          state_ff, state_in;
   logic               first_frame_ff;
   logic               rsp_valid_ff;
   logic [CNT_W-1:0]   cnt_ff;

   // Item context, held for the length of the item.
   logic [INDEX_W-1:0] idx_ff;
   logic               frame_end_ff;
   logic               in_range_ff;
   logic               first_ff;

   // Level datapath.
   logic [PROD_W-1:0]  level_prod_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [LOW_W-1:0]   num_lo_ff;
   logic [LEVEL_W-1:0] quot_ff;

   // Smoothing datapath.
   logic [LEVEL_W-1:0]     avg_mem_ff [SENSOR_COUNT];
   logic [LEVEL_W-1:0]     mem_rd_ff;
   logic signed [34:0]     ema_prod_ff;
   rsp_payload_type        rsp_data_ff;

   logic                   req_take;
   logic                   rsp_take;
   logic                   fin_load;
   logic                   idx_in_range;
   logic [ADDR_W-1:0]      req_addr;
   logic [ADDR_W-1:0]      item_addr;
   logic [PROD_W-1:0]      level_sum;
   logic [DEN_W:0]         trial;
   logic                   trial_ge;
   logic [ALPHA_W-1:0]     alpha_sat;
   logic signed [ALPHA_W:0]   alpha_s;
   logic signed [LEVEL_W:0]   diff_s;
   logic signed [18:0]     ema_sum;
   logic [LEVEL_W-1:0]     new_avg;

   assign req_take     = req_valid && !req_stall;
   assign rsp_take     = rsp_valid_ff && !rsp_stall;
   assign req_stall    = (state_ff != ST_IDLE);
   assign fin_load     = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign idx_in_range = ({{(32-INDEX_W){1'b0}}, req_data.sensor_index} <
                          32'(SENSOR_COUNT));
   assign req_addr     = ADDR_W'(req_data.sensor_index);
   assign item_addr    = ADDR_W'(idx_ff);

   // Numerator = (slope*d + offset) << 7; the top 27 bits seed the remainder,
   // the low bits shift in one per quotient step.
   assign level_sum = level_prod_ff + {{(PROD_W-32){1'b0}}, LEVEL_OFFSET};
   assign trial     = {rem_ff, num_lo_ff[LOW_W-1]};
   assign trial_ge  = (trial >= {1'b0, den_ff});

   // Clamp alpha to one; avg + floor(alpha*(level-avg)/65536) equals the
   // weighted sum of the two terms.
   assign alpha_sat = (smoothing_ff > ALPHA_ONE) ? ALPHA_ONE : smoothing_ff;
   assign alpha_s   = $signed({1'b0, alpha_sat});
   assign diff_s    = $signed({1'b0, quot_ff}) - $signed({1'b0, mem_rd_ff});
   assign ema_sum   = $signed({3'b000, mem_rd_ff}) + ema_prod_ff[34:16];
   assign new_avg   = (first_ff || !in_range_ff) ? quot_ff : ema_sum[LEVEL_W-1:0];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         smoothing_ff <= SMOOTHING_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SMOOTHING_FACTOR: smoothing_ff <= csr_wdata;
            CSR_LEVEL_THRESHOLD:  threshold_ff <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == '0) state_in = ST_EMA;
         ST_EMA:  state_in = ST_FIN;
         ST_FIN:  if (fin_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // First-frame flag: drop it once a frame_end item finishes its final step.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_frame_ff <= 1'b1;
      end else if (fin_load && frame_end_ff) begin
         first_frame_ff <= 1'b0;
      end
   end

   // Capture the item, start both level products.
   always_ff @(posedge clock) begin
      if (req_take) begin
         idx_ff        <= req_data.sensor_index;
         frame_end_ff  <= req_data.frame_end;
         in_range_ff   <= idx_in_range;
         first_ff      <= first_frame_ff;
         level_prod_ff <= {{(PROD_W-SAMPLE_W){1'b0}}, req_data.sample} *
                          {{(PROD_W-24){1'b0}}, LEVEL_SLOPE};
         den_ff        <= {{(DEN_W-SAMPLE_W-1){1'b0}}, 1'b1, req_data.sample} *
                          {{(DEN_W-14){1'b0}}, DEN_SCALE};
      end
   end

   // Restoring divider, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (state_ff == ST_LOAD) begin
         cnt_ff <= CNT_W'(LEVEL_W - 1);
      end else if (state_ff == ST_DIV) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         rem_ff    <= level_sum[PROD_W-1:9];
         num_lo_ff <= {level_sum[8:0], 7'b0};
      end else if (state_ff == ST_DIV) begin
         rem_ff    <= trial_ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_lo_ff <= {num_lo_ff[LOW_W-2:0], 1'b0};
         quot_ff   <= {quot_ff[LEVEL_W-2:0], trial_ge};
      end
   end

   // Average memory: read at acceptance, write back at the final step.
   always_ff @(posedge clock) begin
      if (req_take && idx_in_range) begin
         mem_rd_ff <= avg_mem_ff[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fin_load && in_range_ff) begin
         avg_mem_ff[item_addr] <= new_avg;
      end
   end

   // Smoothing product.
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMA) begin
         ema_prod_ff <= alpha_s * diff_s;
      end
   end

   // Result register: hold while stalled, advance on take.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_load) begin
         rsp_data_ff.sensor_id      <= idx_ff;
         rsp_data_ff.smoothed_level <= new_avg;
         rsp_data_ff.touched        <= (new_avg > threshold_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEXT(a_take_starts_item, clock, reset, req_take, state_ff == ST_LOAD,
      "accepted item did not start the level step")
   `ASSERT_IMPLIES(a_div_rem_bound, clock, reset, state_ff == ST_DIV, rem_ff < den_ff,
      "divider remainder not below divisor")
   `ASSERT_NEXT(a_fin_presents, clock, reset, fin_load,
      rsp_valid_ff && (state_ff == ST_IDLE), "final step did not present the result")
   `ASSERT_IMPLIES(a_first_frame_clear, clock, reset, $fell(first_frame_ff),
      $past(fin_load && frame_end_ff), "first-frame flag dropped outside a frame end")
endmodule

>>> bench/touch_level_checker.sv
`timescale 1ns / 1ps
module touch_level_checker #(
   parameter int SENSOR_COUNT = tsst_pkg::SENSOR_COUNT_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  tsst_pkg::req_payload_type             req_data,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  tsst_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_we,
   input  logic [tsst_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tsst_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                    fail_count,
   output int                                    pending,
   output int                                    checked_count,
   output int                                    touched_count
);
   import tsst_pkg::*;

   logic [ALPHA_W-1:0] alpha_reg;
   logic [LEVEL_W-1:0] threshold_reg;
   logic [LEVEL_W-1:0] sensor_avg [SENSOR_COUNT];
   logic               first_frame_open;
   rsp_payload_type    expected_levels [$];

   // Divider curve in Q3.13, evaluated exactly and truncated.
   function automatic logic [LEVEL_W-1:0] level_from_sample(input logic [SAMPLE_W-1:0] d);
      longint unsigned den;
      longint unsigned num;
      den = 64'd1000000 * (64'd4096 + 64'(d));
      num = 64'd12159100 * 64'(d) + 64'd878894 * (64'd4096 + 64'(d));
      return LEVEL_W'((num * 64'd8192) / den);
   endfunction

   // Advance the smoothing state by one item and return its result.
   function automatic rsp_payload_type smooth_sample(input req_payload_type in_item);
      rsp_payload_type  out_item;
      logic [ALPHA_W-1:0] alpha_eff;
      logic [LEVEL_W-1:0] lvl;
      logic [LEVEL_W-1:0] avg;
      longint unsigned    acc;
      alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
      lvl = level_from_sample(in_item.sample);
      if (int'(in_item.sensor_index) < SENSOR_COUNT) begin
         if (first_frame_open) begin
            avg = lvl;
         end else begin
            acc = 64'(ALPHA_ONE - alpha_eff) * 64'(sensor_avg[in_item.sensor_index])
                + 64'(alpha_eff) * 64'(lvl);
            avg = LEVEL_W'(acc >> 16);
         end
         sensor_avg[in_item.sensor_index] = avg;
      end else begin
         avg = lvl;
      end
      if (in_item.frame_end)
         first_frame_open = 1'b0;
      out_item.sensor_id      = in_item.sensor_index;
      out_item.smoothed_level = avg;
      out_item.touched        = (avg > threshold_reg);
      return out_item;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         alpha_reg        = SMOOTHING_RESET;
         threshold_reg    = THRESHOLD_RESET;
         first_frame_open = 1'b1;
         for (int i = 0; i < SENSOR_COUNT; i++)
            sensor_avg[i] = '0;
         expected_levels.delete();
         pending = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_SMOOTHING_FACTOR)
               alpha_reg = csr_wdata;
            else if (csr_index == CSR_LEVEL_THRESHOLD)
               threshold_reg = csr_wdata[LEVEL_W-1:0];
         end
         if (req_valid && !req_stall)
            expected_levels.push_back(smooth_sample(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $error("result with no item outstanding: id %0d level %0d",
                      rsp_data.sensor_id, rsp_data.smoothed_level);
               fail_count++;
            end else begin
               want = expected_levels.pop_front();
               checked_count++;
               if (rsp_data.touched === 1'b1)
                  touched_count++;
               if (rsp_data.sensor_id !== want.sensor_id) begin
                  $error("sensor_id: expected %0d, got %0d", want.sensor_id,
                         rsp_data.sensor_id);
                  fail_count++;
               end
               if (rsp_data.smoothed_level !== want.smoothed_level) begin
                  $error("smoothed_level: expected %0d, got %0d", want.smoothed_level,
                         rsp_data.smoothed_level);
                  fail_count++;
               end
               if (rsp_data.touched !== want.touched) begin
                  $error("touched: expected %0d, got %0d", want.touched, rsp_data.touched);
                  fail_count++;
               end
            end
         end
         pending = expected_levels.size();
      end
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import tsst_pkg::*;

   // Generous ceiling: the slowest legal run stays well under it.
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_COUNT   = 12;
   localparam int PHASE_ITEMS   = 150;
   localparam int LONG_HOLD     = 400;
   localparam int SENSORS       = SENSOR_COUNT_DEFAULT;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count;
   int pending;
   int checked_count;
   int touched_count;

   // Sender shaping: bursts of up to burst_max items, gaps of up to gap_max.
   int burst_max  = 1;
   int gap_max    = 0;
   int burst_left = 0;
   int items_sent = 0;
   int settings_run = 0;

   // Receiver shaping: stall_mode picks the pattern, long_hold_req asks for
   // one long hold-off that the receiver counts out on its own.
   int stall_mode     = 0;
   bit long_hold_req  = 1'b0;
   bit long_hold_done = 1'b0;
   int hold_left      = 0;
   int rx_cycle       = 0;

   int cycle_count = 0;

   touch_sensor_smoothing_threshold_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   touch_level_checker level_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .touched_count (touched_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bail out if the block hangs; a correct run never gets near this.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: drop stall except during a long hold or when the current
   // pattern asks for it. Mode 0 never stalls, 1 stalls lightly at random,
   // 2 stalls in a repeating rhythm, 3 stalls most of the time.
   always @(posedge clock) begin
      rx_cycle++;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(3, 0) == 0);
            2: rsp_stall <= ((rx_cycle % 13) < 5);
            default: rsp_stall <= ($urandom_range(3, 0) != 0);
         endcase
      end
   end

   // Offer one item and hold it until the block takes it. Gaps are inserted
   // only at burst boundaries, so valid never drops under a stalled item.
   task automatic send_item(input logic [INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] d,
                            input logic fe);
      req_payload_type next_item;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(burst_max, 1);
         gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      next_item.sensor_index = idx;
      next_item.sample       = d;
      next_item.frame_end    = fe;
      req_valid <= 1'b1;
      req_data  <= next_item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid and wait until every outstanding result has come back.
   // The first edge lets the checker account for the last accepted item.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Both registers, one write each, only while the block is idle.
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] alpha, input logic [LEVEL_W-1:0] thr);
      csr_write(CSR_SMOOTHING_FACTOR, alpha);
      csr_write(CSR_LEVEL_THRESHOLD, CSR_DATA_W'(thr));
      settings_run++;
   endtask

   // Mostly valid sensors, a few out-of-range indexes, extremes now and then,
   // and a frame mark that no longer matters after the first frame.
   task automatic send_random_item();
      logic [INDEX_W-1:0]  idx;
      logic [SAMPLE_W-1:0] d;
      logic                fe;
      if ($urandom_range(15, 0) == 0)
         idx = INDEX_W'($urandom_range(31, SENSORS));
      else
         idx = INDEX_W'($urandom_range(SENSORS - 1, 0));
      case ($urandom_range(7, 0))
         0: d = '0;
         1: d = '1;
         default: d = SAMPLE_W'($urandom_range(4095, 0));
      endcase
      fe = ($urandom_range(29, 0) == 0);
      send_item(idx, d, fe);
   endtask

   initial begin
      int order [SENSORS];
      int pick;
      int swap;
      logic [CSR_DATA_W-1:0] alpha;
      logic [LEVEL_W-1:0]    thr;

      // Hold reset, then release.
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First frame: alpha must be ignored here, and the threshold sits
      // exactly on the level of a zero sample, so that one is not touched.
      apply_setting('0, 16'd7199);
      send_item(5'd0, 12'd0, 1'b0);
      send_item(5'd1, 12'd4095, 1'b0);
      send_item(5'd30, 12'd0, 1'b0);
      send_item(5'd31, 12'd4095, 1'b0);
      send_item(5'd0, 12'd2048, 1'b0);
      // Write every sensor once in shuffled order before the frame ends.
      for (int i = 0; i < SENSORS; i++)
         order[i] = i;
      for (int i = SENSORS - 1; i > 0; i--) begin
         pick = $urandom_range(i, 0);
         swap = order[i];
         order[i] = order[pick];
         order[pick] = swap;
      end
      gap_max   = 6;
      burst_max = 4;
      stall_mode = 1;
      for (int i = 0; i < SENSORS; i++)
         send_item(INDEX_W'(order[i]), SAMPLE_W'($urandom_range(4095, 0)), 1'b0);
      // Close the first frame on an out-of-range index.
      send_item(5'd31, 12'd1, 1'b1);
      wait_until_drained();

      // Full weight: average follows the level; zero sample just above threshold.
      apply_setting(ALPHA_ONE, 16'd7198);
      send_item(5'd3, 12'd0, 1'b0);
      send_item(5'd4, 12'd4095, 1'b1);
      wait_until_drained();

      // Zero weight: averages freeze; out-of-range index still reports its level.
      apply_setting('0, 16'hFFFF);
      send_item(5'd3, 12'd4095, 1'b0);
      send_item(5'd30, 12'd4095, 1'b0);
      wait_until_drained();

      // Weight above one saturates to one.
      apply_setting('1, 16'd56996);
      send_item(5'd5, 12'd4095, 1'b0);
      send_item(5'd5, 12'd0, 1'b0);
      send_item(5'd6, 12'd4095, 1'b0);
      wait_until_drained();

      // Random phases, each under its own setting and traffic shape.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: alpha = ALPHA_ONE;
            1: alpha = '0;
            2: alpha = '1;
            3: alpha = 17'd1;
            4: alpha = 17'd65535;
            5: alpha = 17'd65537;
            6: alpha = 17'd8192;
            default: alpha = CSR_DATA_W'($urandom_range(131071, 0));
         endcase
         case (p)
            0: thr = '0;
            1: thr = '1;
            2: thr = 16'd7199;
            3: thr = 16'd56997;
            4: thr = THRESHOLD_RESET;
            default: thr = LEVEL_W'($urandom_range(40000, 10000));
         endcase
         apply_setting(alpha, thr);
         stall_mode = p % 4;
         burst_max  = $urandom_range(8, 1);
         gap_max    = (p % 3 == 0) ? 0 : $urandom_range(30, 5);
         // Keep offering items back to back while the receiver holds off,
         // so the core fills up and has to stall its input.
         if (p == 5) begin
            gap_max = 0;
            long_hold_req = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random_item();
         wait_until_drained();
      end

      // Let any stray result show up before the verdict.
      repeat (40) @(posedge clock);
      $display("Covered %0d items under %0d register settings in %0d cycles.",
               items_sent, settings_run, cycle_count);
      $display("Compared %0d results, %0d of them above threshold.",
               checked_count, touched_count);
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/tsst_pkg.sv
hw/rtl/touch_sensor_smoothing_threshold_core.sv
bench/touch_level_checker.sv
bench/testbench.sv
